// File: sv/mps_pkg.sv
// Shared types, constants and codes for the maze path search block.
// No dependencies; every other file imports this package.
package mps_pkg;

    localparam int GRID_ROWS = 8;
    localparam int GRID_COLS = 8;
    localparam int CELLS     = 64;
    localparam int IDX_W     = 6;
    localparam int DEPTH_W   = 7;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_SOLVE = 1'b1;

    localparam logic [2:0] DIR_ROW_INC = 3'd1;
    localparam logic [2:0] DIR_COL_INC = 3'd2;
    localparam logic [2:0] DIR_ROW_DEC = 3'd3;
    localparam logic [2:0] DIR_COL_DEC = 3'd4;

    typedef struct packed {
        logic       req_type;
        logic [2:0] cell_row;
        logic [2:0] cell_col;
        logic       cell_wall;
        logic [2:0] start_row;
        logic [2:0] start_col;
        logic [2:0] end_row;
        logic [2:0] end_col;
    } req_item_t;

    typedef struct packed {
        logic [2:0] step_row;
        logic [2:0] step_col;
        logic [6:0] step_number;
        logic       found;
        logic       last;
    } rsp_item_t;

    typedef struct packed {
        logic [2:0] row;
        logic [2:0] col;
        logic [2:0] dir;
    } stack_entry_t;

    typedef struct packed {
        logic start;
        logic write_map;
        logic push;
        logic pop;
        logic advance;
        logic out_init;
        logic out_load;
        logic nf_load;
    } cmd_t;

    typedef struct packed {
        logic solve_req;
        logic can_enter;
        logic at_goal;
        logic depth_zero;
        logic depth_full;
        logic dir_done;
        logic out_free;
        logic k_last;
    } status_t;

endpackage

// File: sv/mps_ctrl.sv
// Search sequencer: takes map writes, walks probe, backtrack, path readout and not-found reply.
// Depends on mps_pkg; drives mps_datapath through cmd_t / status_t.
module mps_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  mps_pkg::status_t status,
    output mps_pkg::cmd_t    cmd
);
    import mps_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PROBE = 3'd1;
    localparam logic [2:0] S_POP   = 3'd2;
    localparam logic [2:0] S_OREAD = 3'd3;
    localparam logic [2:0] S_OLOAD = 3'd4;
    localparam logic [2:0] S_NF    = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    if (status.solve_req)
                    begin
                        cmd.start  = 1'b1;
                        state_next = S_PROBE;
                    end
                    else
                    begin
                        cmd.write_map = 1'b1;
                    end
                end
            end
            S_PROBE:
            begin
                if (status.can_enter && !status.depth_full)
                begin
                    cmd.push = 1'b1;
                    if (status.at_goal)
                    begin
                        cmd.out_init = 1'b1;
                        state_next   = S_OREAD;
                    end
                end
                else if (!status.depth_zero)
                begin
                    cmd.pop    = 1'b1;
                    state_next = S_POP;
                end
                else
                begin
                    state_next = S_NF;
                end
            end
            S_POP:
            begin
                if (!status.dir_done)
                begin
                    cmd.advance = 1'b1;
                    state_next  = S_PROBE;
                end
                else if (!status.depth_zero)
                begin
                    cmd.pop = 1'b1;
                end
                else
                begin
                    state_next = S_NF;
                end
            end
            S_OREAD:
            begin
                state_next = S_OLOAD;
            end
            S_OLOAD:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = status.k_last ? S_IDLE : S_OREAD;
                end
            end
            S_NF:
            begin
                if (status.out_free)
                begin
                    cmd.nf_load = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OREAD) |=> (state_reg == S_OLOAD))
        else $error("path readout skipped the load step");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> (state_reg == S_PROBE))
        else $error("search did not begin with a probe");

    assert property (@(posedge clk) disable iff (!rst_n)
        $countones({cmd.push, cmd.pop, cmd.advance, cmd.out_load, cmd.nf_load}) <= 1)
        else $error("conflicting datapath commands");

endmodule

// File: sv/mps_datapath.sv
// Maze maps, search stack memory, cursor, depth counter and result register.
// Depends on mps_pkg; commanded by mps_ctrl.
module mps_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  mps_pkg::req_item_t req,
    input  logic               rsp_ready,
    output logic               rsp_valid,
    output mps_pkg::rsp_item_t rsp,
    input  mps_pkg::cmd_t      cmd,
    output mps_pkg::status_t   status
);
    import mps_pkg::*;

    logic [CELLS-1:0]   wall_reg;
    logic [CELLS-1:0]   visited_reg;
    stack_entry_t       stack_mem [CELLS];
    stack_entry_t       rd_data_reg;
    logic [3:0]         r_reg;
    logic [3:0]         c_reg;
    logic [3:0]         r_next;
    logic [3:0]         c_next;
    logic [2:0]         end_row_reg;
    logic [2:0]         end_col_reg;
    logic [DEPTH_W-1:0] depth_reg;
    logic [DEPTH_W-1:0] depth_next;
    logic [DEPTH_W-1:0] depth_m1;
    logic [IDX_W-1:0]   k_reg;
    logic [IDX_W-1:0]   k_next;
    logic               rsp_valid_reg;
    rsp_item_t          rsp_reg;

    logic [IDX_W-1:0]   idx;
    logic [IDX_W-1:0]   wr_idx;
    logic [IDX_W-1:0]   rd_addr;
    logic               in_grid;
    logic               wr_in_grid;
    logic [2:0]         next_dir;
    logic [3:0]         nb_row;
    logic [3:0]         nb_col;
    logic [DEPTH_W-1:0] k_plus1;
    logic               stack_we;
    stack_entry_t       stack_wdata;

    always_comb
    begin
        idx        = {r_reg[2:0], c_reg[2:0]};
        in_grid    = (r_reg < 4'(GRID_ROWS)) && (c_reg < 4'(GRID_COLS));
        wr_idx     = {req.cell_row, req.cell_col};
        wr_in_grid = ({1'b0, req.cell_row} < 4'(GRID_ROWS))
                  && ({1'b0, req.cell_col} < 4'(GRID_COLS));
        depth_m1   = depth_reg - 7'd1;
        k_plus1    = {1'b0, k_reg} + 7'd1;
        rd_addr    = cmd.pop ? depth_m1[IDX_W-1:0] : k_reg;
        next_dir   = rd_data_reg.dir + 3'd1;
        nb_row     = {1'b0, rd_data_reg.row};
        nb_col     = {1'b0, rd_data_reg.col};
        case (next_dir)
            DIR_ROW_INC: nb_row = {1'b0, rd_data_reg.row} + 4'd1;
            DIR_COL_INC: nb_col = {1'b0, rd_data_reg.col} + 4'd1;
            DIR_ROW_DEC: nb_row = {1'b0, rd_data_reg.row} - 4'd1;
            default:     nb_col = {1'b0, rd_data_reg.col} - 4'd1;
        endcase
    end

    always_comb
    begin
        stack_we    = cmd.push || cmd.advance;
        stack_wdata = cmd.push
                    ? stack_entry_t'{row: r_reg[2:0], col: c_reg[2:0], dir: DIR_ROW_INC}
                    : stack_entry_t'{row: rd_data_reg.row, col: rd_data_reg.col,
                                     dir: next_dir};
        depth_next  = depth_reg;
        r_next      = r_reg;
        c_next      = c_reg;
        k_next      = k_reg;
        if (cmd.start)
        begin
            depth_next = '0;
            r_next     = {1'b0, req.start_row};
            c_next     = {1'b0, req.start_col};
        end
        else if (cmd.push)
        begin
            depth_next = depth_reg + 7'd1;
            r_next     = r_reg + 4'd1;
        end
        else if (cmd.pop)
        begin
            depth_next = depth_m1;
        end
        else if (cmd.advance)
        begin
            depth_next = depth_reg + 7'd1;
            r_next     = nb_row;
            c_next     = nb_col;
        end
        if (cmd.out_init)
        begin
            k_next = '0;
        end
        else if (cmd.out_load)
        begin
            k_next = k_plus1[IDX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wall_reg      <= '0;
            visited_reg   <= '0;
            depth_reg     <= '0;
            r_reg         <= '0;
            c_reg         <= '0;
            k_reg         <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.write_map && wr_in_grid)
            begin
                wall_reg[wr_idx] <= req.cell_wall;
            end
            if (cmd.start)
            begin
                visited_reg <= '0;
            end
            else if (cmd.push)
            begin
                visited_reg[idx] <= 1'b1;
            end
            depth_reg <= depth_next;
            r_reg     <= r_next;
            c_reg     <= c_next;
            k_reg     <= k_next;
            if (cmd.out_load || cmd.nf_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            end_row_reg <= req.end_row;
            end_col_reg <= req.end_col;
        end
        if (cmd.out_load)
        begin
            rsp_reg <= '{step_row: rd_data_reg.row, step_col: rd_data_reg.col,
                         step_number: k_plus1, found: 1'b1,
                         last: (k_plus1 == depth_reg)};
        end
        else if (cmd.nf_load)
        begin
            rsp_reg <= '{step_row: 3'd0, step_col: 3'd0, step_number: 7'd0,
                         found: 1'b0, last: 1'b1};
        end
    end

    always_ff @(posedge clk)
    begin
        if (stack_we)
        begin
            stack_mem[depth_reg[IDX_W-1:0]] <= stack_wdata;
        end
        rd_data_reg <= stack_mem[rd_addr];
    end

    always_comb
    begin
        status.solve_req  = (req.req_type == REQ_SOLVE);
        status.can_enter  = in_grid && !visited_reg[idx] && !wall_reg[idx];
        status.at_goal    = (r_reg == {1'b0, end_row_reg}) && (c_reg == {1'b0, end_col_reg});
        status.depth_zero = (depth_reg == '0);
        status.depth_full = depth_reg[DEPTH_W-1];
        status.dir_done   = (rd_data_reg.dir >= DIR_COL_DEC);
        status.out_free   = !rsp_valid_reg || rsp_ready;
        status.k_last     = (k_plus1 == depth_reg);
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= 7'(CELLS))
        else $error("stack depth beyond capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load || cmd.nf_load) |-> status.out_free)
        else $error("result register overwritten while pending");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |=> visited_reg[$past(idx)])
        else $error("entered cell not marked visited");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp_reg.found) |-> rsp_reg.last)
        else $error("not-found beat without last");

endmodule

// File: sv/maze_path_search.sv
// Maze path search, top level: depth-first solver over a grid of up to 8 x 8 cells.
// Map write: no result. Solve: enter a cell per push, pop stack entries while
// backtracking and retry the next direction of each popped entry; path readout
// then reads and loads each beat through the registered stack read port (plus stall).
// One request at a time.
// Reset: all cells open, visited map clear, no pending beat; the stack needs no clearing.
module maze_path_search (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  mps_pkg::req_item_t req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output mps_pkg::rsp_item_t rsp
);
    import mps_pkg::*;

    cmd_t    cmd;
    status_t status;

    mps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .status    (status),
        .cmd       (cmd)
    );

    mps_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp_ready (rsp_ready),
        .rsp_valid (rsp_valid),
        .rsp       (rsp),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
